/* rtl/ofr_pkg.sv */
// Shared types, constants and helpers of the OpenPGP packet framer.
package ofr_pkg;

  // Width of the running buffer offset (16 to 64)
  localparam int unsigned OFFSET_BITS = 32;
  // Depth of the queue between the decoder and the result stage
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPtrW  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCntW  = $clog2(QDEPTH + 1);

  // Stop tag after reset
  localparam logic [5:0] StopTagReset = 6'd6;

  // Header octet decoding
  localparam logic [7:0] NewLenTwoLo  = 8'd192;
  localparam logic [7:0] NewLenBadLo  = 8'd224;
  localparam logic [7:0] NewLenFive   = 8'd255;
  localparam logic [1:0] OldLenIndef  = 2'd3;
  localparam logic [2:0] OldLenFour   = 3'd4;

  // Result event codes
  localparam logic [1:0] EvHeader  = 2'd0;
  localparam logic [1:0] EvEndOk   = 2'd1;
  localparam logic [1:0] EvCorrupt = 2'd2;

  typedef enum logic [1:0] {
    PH_TAG,
    PH_LEN,
    PH_BODY,
    PH_IDLE
  } phase_e;

  // One result as it leaves the block
  typedef struct packed {
    logic [1:0]  event_res;
    logic [5:0]  tag;
    logic        new_format;
    logic [2:0]  header_length;
    logic [23:0] body_length;
    logic [31:0] packet_offset;
    logic [31:0] cert_length;
    logic        last;
  } ofr_res_t;

  // Everything one input byte causes: a header result, an end result or both
  typedef struct packed {
    logic     hdr_v;
    logic     tail_v;
    ofr_res_t hdr_res;
    ofr_res_t tail_res;
  } ofr_entry_t;

  // Fit an offset into the 32-bit result fields
  function automatic logic [31:0] ofs_to32(input logic [OFFSET_BITS-1:0] v);
    logic [63:0] w;
    w = 64'(v);
    return w[31:0];
  endfunction

endpackage

/* rtl/ofr_cfg_if.sv */
// Configuration write channel carrying the stop tag.
interface ofr_cfg_if;
  logic       valid;
  logic       ready;
  logic [5:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

/* rtl/ofr_in_if.sv */
// Input byte channel of the packet framer.
interface ofr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, data_byte, last_byte, input ready);
  modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

/* rtl/ofr_out_if.sv */
// Result channel of the packet framer.
interface ofr_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  event_res;
  logic [5:0]  tag;
  logic        new_format;
  logic [2:0]  header_length;
  logic [23:0] body_length;
  logic [31:0] packet_offset;
  logic [31:0] cert_length;
  logic        last;

  modport source (output valid, event_res, tag, new_format, header_length, body_length,
                  packet_offset, cert_length, last, input ready);
  modport sink   (input valid, event_res, tag, new_format, header_length, body_length,
                  packet_offset, cert_length, last, output ready);
endinterface

/* rtl/ofr_front.sv */
// Header decoder: one byte per cycle while the queue has room; builds the results it causes.
module ofr_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  ofr_cfg_if.sink            cfg_i,
  ofr_in_if.sink             in_i,
  input  logic               full_i,
  output logic               push_o,
  output ofr_pkg::ofr_entry_t entry_o
);

  localparam int unsigned OW = ofr_pkg::OFFSET_BITS;

  logic [5:0]          stop_tag_q;
  ofr_pkg::phase_e     phase_q, phase_d;
  logic [5:0]          tag_q, tag_d;
  logic                nf_q, nf_d;
  logic [2:0]          need_q, need_d;
  logic [2:0]          seen_q, seen_d;
  logic [23:0]         acc_q, acc_d;
  logic [23:0]         rem_q, rem_d;
  logic [OW-1:0]       off_q, off_d;
  logic [OW-1:0]       start_q, start_d;
  logic [OW-1:0]       cert_len_q, cert_len_d;
  logic                cert_q, cert_d;
  logic                corrupt_q, corrupt_d;

  logic                take;
  logic [7:0]          b;
  logic                fin;
  logic                hdr;
  logic [2:0]          seen_n;

  assign take        = in_i.valid && in_i.ready;
  assign in_i.ready  = !full_i;
  assign cfg_i.ready = 1'b1;
  assign b           = in_i.data_byte;
  assign fin         = in_i.last_byte;
  assign seen_n      = seen_q + 3'd1;

  // Hold the stop tag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stop_tag_q <= ofr_pkg::StopTagReset;
    end else if (cfg_i.valid) begin
      stop_tag_q <= cfg_i.data;
    end
  end

  // Decode the byte and work out the results
  always_comb begin
    phase_d    = phase_q;
    tag_d      = tag_q;
    nf_d       = nf_q;
    need_d     = need_q;
    seen_d     = seen_q;
    acc_d      = acc_q;
    rem_d      = rem_q;
    off_d      = off_q;
    start_d    = start_q;
    cert_len_d = cert_len_q;
    cert_d     = cert_q;
    corrupt_d  = corrupt_q;
    hdr        = 1'b0;
    entry_o    = '0;

    if (take) begin
      case (phase_q)
        ofr_pkg::PH_TAG: begin
          start_d = off_q;
          if (!b[7]) begin
            corrupt_d = 1'b1;
            phase_d   = ofr_pkg::PH_IDLE;
          end else begin
            seen_d = 3'd0;
            acc_d  = 24'd0;
            if (b[6]) begin
              nf_d    = 1'b1;
              tag_d   = b[5:0];
              need_d  = 3'd1;
              phase_d = ofr_pkg::PH_LEN;
            end else begin
              nf_d  = 1'b0;
              tag_d = {2'b00, b[5:2]};
              if (b[1:0] == ofr_pkg::OldLenIndef) begin
                corrupt_d = 1'b1;
                phase_d   = ofr_pkg::PH_IDLE;
              end else begin
                need_d  = 3'd1 << b[1:0];
                phase_d = ofr_pkg::PH_LEN;
              end
            end
          end
        end
        ofr_pkg::PH_LEN: begin
          seen_d = seen_n;
          if (seen_n == 3'd1) begin
            if (nf_q) begin
              if (b < ofr_pkg::NewLenTwoLo) begin
                need_d = 3'd1;
                acc_d  = 24'(b);
              end else if (b < ofr_pkg::NewLenBadLo) begin
                need_d = 3'd2;
                acc_d  = 24'({b - ofr_pkg::NewLenTwoLo, 8'h00});
              end else if (b == ofr_pkg::NewLenFive) begin
                need_d = 3'd5;
                acc_d  = 24'd0;
              end else begin
                corrupt_d = 1'b1;
                phase_d   = ofr_pkg::PH_IDLE;
              end
            end else begin
              if (need_q == ofr_pkg::OldLenFour && b != 8'd0) begin
                corrupt_d = 1'b1;
                phase_d   = ofr_pkg::PH_IDLE;
              end else begin
                acc_d = 24'(b);
              end
            end
          end else if (nf_q && need_q == 3'd2) begin
            acc_d = acc_q + 24'(b) + 24'(ofr_pkg::NewLenTwoLo);
          end else if (nf_q && seen_n == 3'd2) begin
            if (b != 8'd0) begin
              corrupt_d = 1'b1;
              phase_d   = ofr_pkg::PH_IDLE;
            end
          end else begin
            acc_d = {acc_q[15:0], b};
          end
          // Header complete: report it, note a stop packet and move to the body or past an empty one
          if (!corrupt_d && seen_n >= need_d) begin
            hdr = 1'b1;
            if (tag_q == stop_tag_q && start_q != '0) begin
              cert_d     = 1'b1;
              cert_len_d = start_q;
            end
            rem_d = acc_d;
            if (acc_d == 24'd0) begin
              phase_d = cert_d ? ofr_pkg::PH_IDLE : ofr_pkg::PH_TAG;
            end else begin
              phase_d = ofr_pkg::PH_BODY;
            end
          end
        end
        ofr_pkg::PH_BODY: begin
          rem_d = rem_q - 24'd1;
          if (rem_d == 24'd0) begin
            phase_d = cert_q ? ofr_pkg::PH_IDLE : ofr_pkg::PH_TAG;
          end
        end
        default: begin
        end
      endcase

      entry_o.hdr_v                 = hdr;
      entry_o.hdr_res.event_res     = ofr_pkg::EvHeader;
      entry_o.hdr_res.tag           = tag_q;
      entry_o.hdr_res.new_format    = nf_q;
      entry_o.hdr_res.header_length = need_d + 3'd1;
      entry_o.hdr_res.body_length   = acc_d;
      entry_o.hdr_res.packet_offset = ofr_pkg::ofs_to32(start_q);
      entry_o.hdr_res.last          = !fin;

      // End of buffer: give the end result and clear the stream
      if (fin) begin
        entry_o.tail_v        = 1'b1;
        entry_o.tail_res.last = 1'b1;
        if (corrupt_d || phase_d == ofr_pkg::PH_LEN || phase_d == ofr_pkg::PH_BODY) begin
          entry_o.tail_res.event_res = ofr_pkg::EvCorrupt;
        end else begin
          entry_o.tail_res.event_res   = ofr_pkg::EvEndOk;
          entry_o.tail_res.cert_length = cert_d ? ofr_pkg::ofs_to32(cert_len_d)
                                                : ofr_pkg::ofs_to32(off_q + OW'(1));
        end
        phase_d    = ofr_pkg::PH_TAG;
        tag_d      = '0;
        nf_d       = 1'b0;
        need_d     = '0;
        seen_d     = '0;
        acc_d      = '0;
        rem_d      = '0;
        off_d      = '0;
        start_d    = '0;
        cert_len_d = '0;
        cert_d     = 1'b0;
        corrupt_d  = 1'b0;
      end else begin
        off_d = off_q + OW'(1);
      end
    end
  end

  assign push_o = take && (hdr || fin);

  // Advance the stream state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= ofr_pkg::PH_TAG;
      tag_q      <= '0;
      nf_q       <= 1'b0;
      need_q     <= '0;
      seen_q     <= '0;
      acc_q      <= '0;
      rem_q      <= '0;
      off_q      <= '0;
      start_q    <= '0;
      cert_len_q <= '0;
      cert_q     <= 1'b0;
      corrupt_q  <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      tag_q      <= tag_d;
      nf_q       <= nf_d;
      need_q     <= need_d;
      seen_q     <= seen_d;
      acc_q      <= acc_d;
      rem_q      <= rem_d;
      off_q      <= off_d;
      start_q    <= start_d;
      cert_len_q <= cert_len_d;
      cert_q     <= cert_d;
      corrupt_q  <= corrupt_d;
    end
  end

endmodule

/* rtl/ofr_queue.sv */
// Short queue of result entries between the decoder and the result stage.
module ofr_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  ofr_pkg::ofr_entry_t entry_i,
  output logic                full_o,
  input  logic                pop_i,
  output ofr_pkg::ofr_entry_t entry_o,
  output logic                empty_o
);

  localparam int unsigned PW = ofr_pkg::QPtrW;
  localparam int unsigned CW = ofr_pkg::QCntW;

  ofr_pkg::ofr_entry_t slot_q [ofr_pkg::QDEPTH];
  logic [PW-1:0] wr_q, wr_d;
  logic [PW-1:0] rd_q, rd_d;
  logic [CW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CW'(ofr_pkg::QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign entry_o = slot_q[rd_q];

  // Advance pointers and fill count
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PW'(ofr_pkg::QDEPTH - 1)) ? '0 : wr_q + PW'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == PW'(ofr_pkg::QDEPTH - 1)) ? '0 : rd_q + PW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Store the entry
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= entry_i;
    end
  end

endmodule

/* rtl/ofr_back.sv */
// Result stage: splits queued entries into single result transfers.
module ofr_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ofr_pkg::ofr_entry_t entry_i,
  input  logic                empty_i,
  output logic                pop_o,
  ofr_out_if.source           res_o
);

  ofr_pkg::ofr_res_t out_q, out_d;
  logic              out_v_q, out_v_d;
  ofr_pkg::ofr_res_t pend_q, pend_d;
  logic              pend_v_q, pend_v_d;
  logic              load;

  assign load = !out_v_q || res_o.ready;

  // Pick the next result: a held end result first, then the queue head
  always_comb begin
    out_d    = out_q;
    out_v_d  = out_v_q;
    pend_d   = pend_q;
    pend_v_d = pend_v_q;
    pop_o    = 1'b0;
    if (load) begin
      if (pend_v_q) begin
        out_d    = pend_q;
        out_v_d  = 1'b1;
        pend_v_d = 1'b0;
      end else if (!empty_i) begin
        pop_o   = 1'b1;
        out_v_d = 1'b1;
        if (entry_i.hdr_v) begin
          out_d    = entry_i.hdr_res;
          pend_d   = entry_i.tail_res;
          pend_v_d = entry_i.tail_v;
        end else begin
          out_d = entry_i.tail_res;
        end
      end else begin
        out_v_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      pend_v_q <= 1'b0;
    end else begin
      out_v_q  <= out_v_d;
      pend_v_q <= pend_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    pend_q <= pend_d;
  end

  // Drive the result channel
  assign res_o.valid         = out_v_q;
  assign res_o.event_res     = out_q.event_res;
  assign res_o.tag           = out_q.tag;
  assign res_o.new_format    = out_q.new_format;
  assign res_o.header_length = out_q.header_length;
  assign res_o.body_length   = out_q.body_length;
  assign res_o.packet_offset = out_q.packet_offset;
  assign res_o.cert_length   = out_q.cert_length;
  assign res_o.last          = out_q.last;

  // A held end result always follows a header shown in the output register
  a_pend_behind_hdr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_v_q |-> out_v_q && out_q.event_res == ofr_pkg::EvHeader && !out_q.last)
    else $error("end result held without a header in front");

  // The held result is the end of a buffer
  a_pend_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_v_q |-> pend_q.last && pend_q.event_res != ofr_pkg::EvHeader)
    else $error("held result is not an end result");

  // Never pop an empty queue
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> !empty_i)
    else $error("pop from empty queue");

  // A held result is not dropped while the receiver stalls
  a_pend_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_v_q && !res_o.ready |=> pend_v_q)
    else $error("held end result lost under stall");

endmodule

/* rtl/openpgp_packet_framer.sv */
// Top level of the OpenPGP packet framer.
//
// Bytes of an unarmored OpenPGP buffer enter on in_i, one per transfer, with
// last_byte set on the final octet. Each completed packet header gives one
// result on res_o; the final octet also gives one end result (buffer sound,
// with the certificate length, or buffer corrupt). A byte can thus cause up
// to two results, the header result going first.
// The user must write the stop tag on cfg_i only while the block is idle; the
// block itself does not enforce this. cfg_i is always ready. It resets to 6.
// Throughput: one byte per cycle while the queue has room, set by the header
// decoder. A byte that causes two results holds its end result in the result
// stage while the header result goes out.
// A result passes from the decoder into the four-entry queue and from there
// into the output register that drives res_o.
// A stall on res_o fills the queue; in_i drops ready once the queue is full
// and raises it again as results drain. Reset empties the queue and output
// register and returns the decoder to the start of a buffer.
module openpgp_packet_framer (
  input  logic      clk_i,
  input  logic      rst_ni,
  ofr_cfg_if.sink   cfg_i,
  ofr_in_if.sink    in_i,
  ofr_out_if.source res_o
);

  ofr_pkg::ofr_entry_t push_entry;
  ofr_pkg::ofr_entry_t head_entry;
  logic                push;
  logic                full;
  logic                pop;
  logic                empty;

  ofr_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_i),
    .in_i    (in_i),
    .full_i  (full),
    .push_o  (push),
    .entry_o (push_entry)
  );

  ofr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (full),
    .pop_i   (pop),
    .entry_o (head_entry),
    .empty_o (empty)
  );

  ofr_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .entry_i (head_entry),
    .empty_i (empty),
    .pop_o   (pop),
    .res_o   (res_o)
  );

endmodule

/* test/openpgp_packet_framer_checker.sv */
// Result checker for the OpenPGP packet framer: follows every transfer and compares results.
`timescale 1ns / 1ps

module openpgp_packet_framer_checker
  import ofr_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  ofr_cfg_if   cfg_mon,
  ofr_in_if    in_mon,
  ofr_out_if   res_mon,
  output int   fail_count_o,
  output int   pending_o,
  output int   header_count_o,
  output int   sound_count_o,
  output int   corrupt_count_o
);

  localparam int MaxReports = 100;

  // Own copy of the framer state
  logic [5:0]             stop_tag_q;
  phase_e                 fr_phase;
  logic [5:0]             fr_tag;
  logic                   fr_new;
  logic [2:0]             len_need;
  logic [2:0]             len_seen;
  logic [23:0]            len_acc;
  logic [23:0]            body_left;
  logic [OFFSET_BITS-1:0] byte_ofs;
  logic [OFFSET_BITS-1:0] pkt_ofs;
  logic [OFFSET_BITS-1:0] cert_ofs;
  logic                   cert_hit;
  logic                   stream_bad;
  int                     results_seen;

  // Results still owed by the block, oldest first
  ofr_res_t due_results[$];

  task automatic report_mismatch(input string msg);
    fail_count_o++;
    if (fail_count_o <= MaxReports) begin
      $display("[%0t] mismatch on result %0d: %s", $time, results_seen, msg);
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s is 0x%0h, predicted 0x%0h", name, got, want));
    end
  endtask

  task automatic byte_offs_clear();
    byte_ofs   = '0;
    pkt_ofs    = '0;
    cert_ofs   = '0;
    cert_hit   = 1'b0;
    stream_bad = 1'b0;
  endtask

  // Return to the start of a buffer; the stop tag is kept
  task automatic clear_stream();
    fr_phase   = PH_TAG;
    fr_tag     = '0;
    fr_new     = 1'b0;
    len_need   = '0;
    len_seen   = '0;
    len_acc    = '0;
    body_left  = '0;
    byte_offs_clear();
  endtask

  // Bad header: ignore everything up to the last octet
  task automatic mark_bad();
    stream_bad = 1'b1;
    fr_phase   = PH_IDLE;
  endtask

  // Work out the results caused by one accepted octet
  task automatic frame_octet(input logic [7:0] octet, input logic fin);
    logic     hdr_done;
    ofr_res_t r;
    hdr_done = 1'b0;
    case (fr_phase)
      PH_TAG: begin
        pkt_ofs  = byte_ofs;
        len_seen = '0;
        len_acc  = '0;
        if (!octet[7]) begin
          mark_bad();
        end else if (octet[6]) begin
          fr_new   = 1'b1;
          fr_tag   = octet[5:0];
          len_need = 3'd1;
          fr_phase = PH_LEN;
        end else begin
          fr_new = 1'b0;
          fr_tag = {2'b00, octet[5:2]};
          if (octet[1:0] == OldLenIndef) begin
            mark_bad();
          end else begin
            len_need = 3'd1 << octet[1:0];
            fr_phase = PH_LEN;
          end
        end
      end
      PH_LEN: begin
        len_seen = len_seen + 3'd1;
        if (len_seen == 3'd1) begin
          if (fr_new) begin
            if (octet < NewLenTwoLo) begin
              len_need = 3'd1;
              len_acc  = 24'(octet);
            end else if (octet < NewLenBadLo) begin
              len_need = 3'd2;
              len_acc  = {8'h00, octet - NewLenTwoLo, 8'h00};
            end else if (octet == NewLenFive) begin
              len_need = 3'd5;
              len_acc  = '0;
            end else begin
              mark_bad();
            end
          end else if (len_need == OldLenFour && octet != 8'h00) begin
            mark_bad();
          end else begin
            len_acc = 24'(octet);
          end
        end else if (fr_new && len_need == 3'd2) begin
          len_acc = len_acc + 24'(octet) + 24'(NewLenTwoLo);
        end else if (fr_new && len_seen == 3'd2) begin
          // high octet of a five-octet length must be clear
          if (octet != 8'h00) begin
            mark_bad();
          end
        end else begin
          len_acc = {len_acc[15:0], octet};
        end
        // Header complete: note a stop packet and move to the body or past an empty one
        if (!stream_bad && len_seen >= len_need) begin
          hdr_done = 1'b1;
          if (fr_tag == stop_tag_q && pkt_ofs != '0) begin
            cert_hit = 1'b1;
            cert_ofs = pkt_ofs;
          end
          body_left = len_acc;
          if (body_left == '0) begin
            fr_phase = cert_hit ? PH_IDLE : PH_TAG;
          end else begin
            fr_phase = PH_BODY;
          end
        end
      end
      PH_BODY: begin
        body_left = body_left - 24'd1;
        if (body_left == '0) begin
          fr_phase = cert_hit ? PH_IDLE : PH_TAG;
        end
      end
      default: begin
      end
    endcase

    if (hdr_done) begin
      r               = '0;
      r.event_res     = EvHeader;
      r.tag           = fr_tag;
      r.new_format    = fr_new;
      r.header_length = len_need + 3'd1;
      r.body_length   = len_acc;
      r.packet_offset = 32'(pkt_ofs);
      r.last          = !fin;
      due_results.push_back(r);
    end

    if (fin) begin
      r      = '0;
      r.last = 1'b1;
      if (stream_bad || fr_phase == PH_LEN || fr_phase == PH_BODY) begin
        r.event_res = EvCorrupt;
      end else begin
        r.event_res   = EvEndOk;
        r.cert_length = cert_hit ? 32'(cert_ofs) : 32'(byte_ofs + 1'b1);
      end
      due_results.push_back(r);
      clear_stream();
    end else begin
      byte_ofs = byte_ofs + 1'b1;
    end
  endtask

  // Compare one result transfer with the oldest prediction
  task automatic check_result();
    ofr_res_t got;
    ofr_res_t want;
    results_seen++;
    got.event_res     = res_mon.event_res;
    got.tag           = res_mon.tag;
    got.new_format    = res_mon.new_format;
    got.header_length = res_mon.header_length;
    got.body_length   = res_mon.body_length;
    got.packet_offset = res_mon.packet_offset;
    got.cert_length   = res_mon.cert_length;
    got.last          = res_mon.last;
    if (due_results.size() == 0) begin
      report_mismatch("result with no octet to account for it");
      return;
    end
    want = due_results.pop_front();
    check_field("event_res", 32'(got.event_res), 32'(want.event_res));
    check_field("tag", 32'(got.tag), 32'(want.tag));
    check_field("new_format", 32'(got.new_format), 32'(want.new_format));
    check_field("header_length", 32'(got.header_length), 32'(want.header_length));
    check_field("body_length", 32'(got.body_length), 32'(want.body_length));
    check_field("packet_offset", got.packet_offset, want.packet_offset);
    check_field("cert_length", got.cert_length, want.cert_length);
    check_field("last", 32'(got.last), 32'(want.last));
    if (want.event_res == EvHeader) begin
      header_count_o++;
    end else if (want.event_res == EvEndOk) begin
      sound_count_o++;
    end else begin
      corrupt_count_o++;
    end
  endtask

  // Sample all channels at the rising edge; results go first, then the new octet
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stop_tag_q = StopTagReset;
      clear_stream();
      due_results.delete();
      pending_o       = 0;
      fail_count_o    = 0;
      header_count_o  = 0;
      sound_count_o   = 0;
      corrupt_count_o = 0;
      results_seen    = 0;
    end else begin
      if (res_mon.valid === 1'b1 && res_mon.ready === 1'b1) begin
        check_result();
      end
      if (cfg_mon.valid === 1'b1 && cfg_mon.ready === 1'b1) begin
        stop_tag_q = cfg_mon.data;
      end
      if (in_mon.valid === 1'b1 && in_mon.ready === 1'b1) begin
        frame_octet(in_mon.data_byte, in_mon.last_byte);
      end
      pending_o = due_results.size();
    end
  end

endmodule

/* test/openpgp_packet_framer_tb.sv */
// Stimulus and verdict for the OpenPGP packet framer: directed and random buffers.
`timescale 1ns / 1ps

module openpgp_packet_framer_tb;
  import ofr_pkg::*;

  localparam int          RandOctets     = 1500;
  localparam int          NumPhases      = 5;
  localparam int          MaxGap         = 13;
  localparam int          DrainCycles    = 8;
  localparam int          CycleLimit     = 400000;
  localparam int          NewTwoMax      = 8383;
  localparam logic [1:0]  OldLenTypeFour = 2'd2;

  logic clk_i = 1'b0;
  logic rst_ni;

  ofr_cfg_if cfg_ch ();
  ofr_in_if  in_ch ();
  ofr_out_if res_ch ();

  int fail_count;
  int pending;
  int header_count;
  int sound_count;
  int corrupt_count;
  int cycle_count;
  int total_octets;
  int buffer_count;

  logic       burst_in;
  logic       burst_out;
  logic [5:0] stop_tag_now;
  logic [7:0] octets_q[$];

  openpgp_packet_framer dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_ch),
    .in_i  (in_ch),
    .res_o (res_ch)
  );

  openpgp_packet_framer_checker u_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_mon        (cfg_ch),
    .in_mon         (in_ch),
    .res_mon        (res_ch),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .header_count_o (header_count),
    .sound_count_o  (sound_count),
    .corrupt_count_o(corrupt_count)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Append one well-formed packet, picking a random length encoding that fits
  task automatic add_packet(input logic [5:0] tag, input int body_len, input logic new_fmt);
    int len_type;
    if (new_fmt) begin
      octets_q.push_back({2'b11, tag});
      if (body_len < int'(NewLenTwoLo) && $urandom_range(0, 3) != 0) begin
        octets_q.push_back(8'(body_len));
      end else if (body_len >= int'(NewLenTwoLo) && body_len <= NewTwoMax &&
                   $urandom_range(0, 1) == 0) begin
        octets_q.push_back(NewLenTwoLo + 8'((body_len - int'(NewLenTwoLo)) >> 8));
        octets_q.push_back(8'(body_len - int'(NewLenTwoLo)));
      end else begin
        octets_q.push_back(NewLenFive);
        octets_q.push_back(8'h00);
        octets_q.push_back(8'(body_len >> 16));
        octets_q.push_back(8'(body_len >> 8));
        octets_q.push_back(8'(body_len));
      end
    end else begin
      len_type = (body_len < 256) ? $urandom_range(0, 2) :
                 (body_len < 65536) ? $urandom_range(1, 2) : 2;
      octets_q.push_back({2'b10, tag[3:0], 2'(len_type)});
      if (len_type == int'(OldLenTypeFour)) begin
        octets_q.push_back(8'h00);
        octets_q.push_back(8'(body_len >> 16));
      end
      if (len_type >= 1) begin
        octets_q.push_back(8'(body_len >> 8));
      end
      octets_q.push_back(8'(body_len));
    end
    repeat (body_len) octets_q.push_back(8'($urandom_range(0, 255)));
  endtask

  // Send the buffer held in octets_q, one transfer per octet, with random gaps
  task automatic send_buffer();
    int idx;
    int gap;
    for (idx = 0; idx < octets_q.size(); idx++) begin
      gap = burst_in ? 0 : $urandom_range(0, MaxGap);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      in_ch.valid     <= 1'b1;
      in_ch.data_byte <= octets_q[idx];
      in_ch.last_byte <= (idx == octets_q.size() - 1);
      do @(posedge clk_i); while (in_ch.ready !== 1'b1);
      @(negedge clk_i);
    end
    total_octets += octets_q.size();
    buffer_count++;
  endtask

  // Hold the input idle until every predicted result has arrived
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  // Result side: stall a random number of cycles before each transfer
  initial begin : result_sink
    int stall;
    res_ch.ready <= 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      stall = burst_out ? 0 : $urandom_range(0, MaxGap);
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk_i); while (res_ch.valid !== 1'b1);
      @(negedge clk_i);
    end
  end

  // End the run if it stops making progress
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results still owed", cycle_count, pending);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : stimulus
    logic [5:0] tag_plan[NumPhases];
    logic [5:0] tag;
    logic       stopped;
    int         phase_idx;
    int         phase_octets;
    int         useful;
    int         shape;
    int         start;
    int         pick;
    int         body_len;

    rst_ni          <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.data_byte <= '0;
    in_ch.last_byte <= 1'b0;
    cfg_ch.valid    <= 1'b0;
    cfg_ch.data     <= '0;
    burst_in     = 1'b0;
    burst_out    = 1'b0;
    total_octets = 0;
    buffer_count = 0;
    stop_tag_now = StopTagReset;
    tag_plan     = '{StopTagReset, 6'd63, 6'd0, 6'd15, 6'($urandom_range(1, 62))};

    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed buffers under the reset stop tag
    // two empty packets, old tag 0 and new tag 63, buffer ends well
    octets_q = '{8'h80, 8'h00, 8'hFF, 8'h00};
    send_buffer();
    // largest five-octet length, header completes on the last octet
    octets_q = '{8'hC1, 8'hFF, 8'h00, 8'hFF, 8'hFF, 8'hFF};
    send_buffer();
    // old tag 15, four-octet length, header completes on the last octet
    octets_q = '{8'hBE, 8'h00, 8'hFF, 8'hFF, 8'hFE};
    send_buffer();
    // tag octet without its top bit
    octets_q = '{8'h7F};
    send_buffer();
    // old indefinite length
    octets_q = '{8'h83, 8'h00};
    send_buffer();
    // new first length octet in the reserved range
    octets_q = '{8'hC2, 8'hFE};
    send_buffer();
    // old four-octet length with a nonzero high octet
    octets_q = '{8'h82, 8'h01, 8'h00};
    send_buffer();
    // five-octet length of 16 MiB or more
    octets_q = '{8'hC2, 8'hFF, 8'h01};
    send_buffer();
    // stop tag at offset zero does not count; the second one ends the certificate
    octets_q.delete();
    add_packet(StopTagReset, 0, 1'b0);
    add_packet(StopTagReset, 1, 1'b1);
    octets_q.push_back(8'h12);
    octets_q.push_back(8'h34);
    send_buffer();

    for (phase_idx = 0; phase_idx < NumPhases; phase_idx++) begin
      // Change the stop tag only once the block has gone quiet
      if (phase_idx > 0) begin
        wait_drained();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= tag_plan[phase_idx];
        do @(posedge clk_i); while (cfg_ch.ready !== 1'b1);
        @(negedge clk_i);
        cfg_ch.valid <= 1'b0;
        stop_tag_now = tag_plan[phase_idx];
      end

      phase_octets = 0;
      while (phase_octets < RandOctets / NumPhases) begin
        octets_q.delete();
        burst_in  = ($urandom_range(0, 4) == 0);
        burst_out = ($urandom_range(0, 4) == 0);
        shape     = $urandom_range(0, 9);
        if (shape == 9) begin
          // noise
          repeat ($urandom_range(1, 6)) octets_q.push_back(8'($urandom_range(0, 255)));
          useful = octets_q.size();
        end else begin
          // well-formed packets, short bodies mostly
          stopped = 1'b0;
          repeat ($urandom_range(1, 5)) begin
            if (!stopped) begin
              start    = octets_q.size();
              tag      = ($urandom_range(0, 3) == 0) ? stop_tag_now : 6'($urandom_range(0, 63));
              pick     = $urandom_range(0, 19);
              body_len = (pick < 16) ? $urandom_range(0, 8) :
                         (pick < 19) ? $urandom_range(9, 40) : $urandom_range(192, 260);
              add_packet(tag, body_len, (tag > 6'd15) || ($urandom_range(0, 1) == 1));
              stopped = (tag == stop_tag_now) && (start != 0);
            end
          end
          // cut the buffer short, most often inside a header or body
          if (shape == 7 && octets_q.size() > 1) begin
            repeat ($urandom_range(1, (octets_q.size() > 4) ? 4 : octets_q.size() - 1))
              void'(octets_q.pop_back());
          end
          // finish on a malformed header
          if (shape == 8) begin
            case ($urandom_range(0, 4))
              0: octets_q.push_back(8'($urandom_range(0, 127)));
              1: octets_q.push_back({2'b10, 4'($urandom_range(0, 15)), OldLenIndef});
              2: begin
                octets_q.push_back({2'b11, 6'($urandom_range(0, 63))});
                octets_q.push_back(8'($urandom_range(int'(NewLenBadLo), 254)));
              end
              3: begin
                octets_q.push_back({2'b10, 4'($urandom_range(0, 15)), OldLenTypeFour});
                octets_q.push_back(8'($urandom_range(1, 255)));
              end
              default: begin
                octets_q.push_back({2'b11, 6'($urandom_range(0, 63))});
                octets_q.push_back(NewLenFive);
                octets_q.push_back(8'($urandom_range(1, 255)));
              end
            endcase
          end
          useful = octets_q.size();
          // trailing octets the block should drop
          if (stopped || shape == 8) begin
            repeat ($urandom_range(0, 3)) octets_q.push_back(8'($urandom_range(0, 255)));
          end
        end
        send_buffer();
        phase_octets += useful;
      end
    end

    wait_drained();
    $display("Covered %0d buffers, %0d octets, stop tags 6, 63, 0, 15 and %0d.",
             buffer_count, total_octets, tag_plan[NumPhases-1]);
    $display("Checked %0d headers, %0d sound ends and %0d corrupt ends.",
             header_count, sound_count, corrupt_count);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
